[rtl/tprc_pkg.sv]
// Package for the timer prescale/reload calculator.
// Holds status codes, field widths and the divider request/response types.
// No dependencies.
package tprc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CntW  = 6;

    localparam logic [DataW-1:0] CoreClockReset = 32'd8000000;
    localparam logic [DataW-1:0] ReloadLimit    = 32'h0000_FFFF;
    localparam logic [DataW-1:0] PrescaleMax    = 32'h0000_FFFF;

    localparam logic [3:0] TimerFirst = 4'd1;
    localparam logic [3:0] TimerLast  = 4'd4;

    // Divider codes below this one divide the core clock by one
    localparam logic [2:0] ApbDivFirstShift = 3'd4;
    localparam logic [2:0] ApbDivShiftBias  = 3'd3;

    localparam logic [1:0] StatusOk        = 2'd0;
    localparam logic [1:0] StatusBadTimer  = 2'd1;
    localparam logic [1:0] StatusLowFreq   = 2'd2;
    localparam logic [1:0] StatusOverflow  = 2'd3;

    // Register byte address bit that selects the register
    localparam logic RegCoreClock = 1'b0;
    localparam logic RegApbDiv    = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DataW-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/tprc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tprc_pkg for the request/response types.
module tprc_div
    import tprc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DataW-1:0] rem_reg;
    logic [DataW-1:0] quo_reg;
    logic [DataW-1:0] divisor_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DataW:0]   trial;
    logic [DataW:0]   diff;
    logic             fits;

    // Shift the next dividend bit into the partial remainder and try the subtract
    assign trial = {rem_reg, quo_reg[DataW-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = ~diff[DataW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // Pulse done on the last quotient bit
            done_reg <= !req.start && busy_reg && (cnt_reg == CntW'(1));
            if (req.start) begin
                rem_reg     <= '0;
                quo_reg     <= req.dividend;
                divisor_reg <= req.divisor;
                cnt_reg     <= CntW'(DataW);
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[DataW-1:0] : trial[DataW-1:0];
                quo_reg  <= {quo_reg[DataW-2:0], fits};
                cnt_reg  <= cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/timer_prescale_reload_calc_core.sv]
// Timer prescale/reload calculator: one item in, one result out.
// Flow: a bad timer or a low frequency goes straight to the output register; otherwise the
// item runs the base, prescale and reload divisions in turn on the one bit-serial divider,
// stopping after the prescale division on a prescaler overflow, then loads the output register.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: synchronous, active low; clears control, core_clock to 8000000 and
// the divider code to 0.
module timer_prescale_reload_calc_core
    import tprc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] timer_number, [35:4] frequency, [39:36] zero
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [17:2] prescale, [33:18] reload, rest zero
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_PRE,
        ST_REL,
        ST_PUT
    } state_t;

    state_t           state_reg;
    logic [DataW-1:0] core_clock_reg;
    logic [2:0]       apb_div_reg;

    logic [DataW-1:0] base_reg;
    logic [15:0]      pre_reg;
    logic [1:0]       res_status_reg;
    logic [15:0]      res_prescale_reg;
    logic [15:0]      res_reload_reg;

    logic             m_tvalid_reg;
    logic [1:0]       m_status_reg;
    logic [15:0]      m_prescale_reg;
    logic [15:0]      m_reload_reg;

    logic             div_start_reg;
    logic [DataW-1:0] div_dividend_reg;
    logic [DataW-1:0] div_divisor_reg;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [3:0]       in_timer;
    logic [DataW-1:0] in_freq;
    logic [DataW-1:0] in_half;
    logic [2:0]       bus_shift;
    logic             cfg_write;
    logic             div_go;

    assign in_timer  = s_tdata[3:0];
    assign in_freq   = s_tdata[35:4];
    assign in_half   = {1'b0, in_freq[DataW-1:1]};
    assign bus_shift = (apb_div_reg < ApbDivFirstShift) ? 3'd0
                                                        : apb_div_reg - ApbDivShiftBias;
    assign cfg_write = psel & penable & pwrite & pready;

    // Start a division on a good item, after the base one and after an in-range prescale
    assign div_go = (state_reg == ST_IDLE && s_tvalid
                     && !(in_timer < TimerFirst || in_timer > TimerLast)
                     && in_half != '0)
                 || (state_reg == ST_BASE && div_rsp.done)
                 || (state_reg == ST_PRE && div_rsp.done
                     && !(div_rsp.quotient > PrescaleMax));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_clock_reg <= CoreClockReset;
            apb_div_reg    <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                RegCoreClock: core_clock_reg <= pwdata;
                RegApbDiv:    apb_div_reg    <= pwdata[2:0];
                default:      ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegApbDiv) ? {29'd0, apb_div_reg} : core_clock_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= div_go;
            // Drop the result once taken, unless a new one is loaded this cycle
            if (m_tvalid_reg && m_tready && state_reg != ST_PUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        res_prescale_reg <= '0;
                        res_reload_reg   <= '0;
                        if (in_timer < TimerFirst || in_timer > TimerLast) begin
                            res_status_reg <= StatusBadTimer;
                            state_reg      <= ST_PUT;
                        end else if (in_half == '0) begin
                            res_status_reg <= StatusLowFreq;
                            state_reg      <= ST_PUT;
                        end else begin
                            div_dividend_reg <= core_clock_reg >> bus_shift;
                            div_divisor_reg  <= in_half;
                            state_reg        <= ST_BASE;
                        end
                    end
                end
                ST_BASE: begin
                    if (div_rsp.done) begin
                        base_reg         <= div_rsp.quotient;
                        div_dividend_reg <= div_rsp.quotient;
                        div_divisor_reg  <= ReloadLimit;
                        state_reg        <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient > PrescaleMax) begin
                            res_status_reg <= StatusOverflow;
                            state_reg      <= ST_PUT;
                        end else begin
                            pre_reg          <= div_rsp.quotient[15:0];
                            div_dividend_reg <= base_reg;
                            div_divisor_reg  <= {16'd0, div_rsp.quotient[15:0]} + 32'd1;
                            state_reg        <= ST_REL;
                        end
                    end
                end
                ST_REL: begin
                    if (div_rsp.done) begin
                        res_status_reg   <= StatusOk;
                        res_prescale_reg <= pre_reg;
                        res_reload_reg   <= div_rsp.quotient[15:0];
                        state_reg        <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg   <= 1'b1;
                        m_status_reg   <= res_status_reg;
                        m_prescale_reg <= res_prescale_reg;
                        m_reload_reg   <= res_reload_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dividend_reg;
    assign div_req.divisor  = div_divisor_reg;

    tprc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_reload_reg, m_prescale_reg, m_status_reg};

endmodule

[rtl/tprc_chk.sv]
// Port-level checker for the timer prescale/reload calculator, bound to the top.
// Depends on tprc_pkg for the status codes.
module tprc_chk
    import tprc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken before the first was processed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != StatusOk |-> m_tdata[33:2] == 32'd0)
        else $error("error result carries nonzero prescale or reload");

    a_reload_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == StatusOk |-> m_tdata[33:18] != 16'hFFFF)
        else $error("reload reached the limit");

endmodule

bind timer_prescale_reload_calc_core tprc_chk u_tprc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tprc_result_checker.sv]
// Result checker for the timer prescale/reload calculator.
// Watches the APB port and both streams, predicts each result and compares it.
// Depends on tprc_pkg for status codes, register selects and limits.
`timescale 1ns / 100ps

module tprc_result_checker
    import tprc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] timer_number, [35:4] frequency, [39:36] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [1:0] status, [17:2] prescale, [33:18] reload, rest zero
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          ok_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] prescale;
        logic [15:0] reload;
    } timing_t;

    timing_t            expected_timing_q[$];
    logic [DataW-1:0]   cfg_core_clock = CoreClockReset;
    logic [2:0]         cfg_div_code   = 3'd0;
    int                 fails     = 0;
    int                 n_results = 0;
    int                 n_ok      = 0;

    function automatic timing_t predict_timing(input logic [3:0] tnum, input logic [31:0] freq);
        timing_t     r;
        logic [2:0]  shift;
        logic [31:0] bus, half, base, pre, rel;
        r = '0;
        if (tnum < TimerFirst || tnum > TimerLast) begin
            r.status = StatusBadTimer;
        end else begin
            half = freq >> 1;
            if (half == 32'd0) begin
                r.status = StatusLowFreq;
            end else begin
                shift = (cfg_div_code < ApbDivFirstShift) ? 3'd0
                                                           : cfg_div_code - ApbDivShiftBias;
                bus   = cfg_core_clock >> shift;
                base  = bus / half;
                pre   = base / ReloadLimit;
                if (pre > PrescaleMax) begin
                    r.status = StatusOverflow;
                end else begin
                    rel        = base / (pre + 32'd1);
                    r.status   = StatusOk;
                    r.prescale = pre[15:0];
                    r.reload   = rel[15:0];
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        timing_t exp_r;
        if (!aresetn) begin
            cfg_core_clock = CoreClockReset;
            cfg_div_code   = 3'd0;
            expected_timing_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == RegApbDiv) cfg_div_code = pwdata[2:0];
                    else                       cfg_core_clock = pwdata;
                end else if (paddr[2] == RegApbDiv) begin
                    check_field("divider code readback", {29'd0, cfg_div_code}, prdata);
                end else begin
                    check_field("core clock readback", cfg_core_clock, prdata);
                end
            end
            // Retire the oldest expectation before queuing the one for a new item
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_timing_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                             $time, m_tdata);
                    fails++;
                end else begin
                    exp_r = expected_timing_q.pop_front();
                    if (exp_r.status == StatusOk) n_ok++;
                    check_field("status", 32'(exp_r.status), 32'(m_tdata[1:0]));
                    check_field("prescale", 32'(exp_r.prescale), 32'(m_tdata[17:2]));
                    check_field("reload", 32'(exp_r.reload), 32'(m_tdata[33:18]));
                    check_field("padding", 32'd0, 32'(m_tdata[39:34]));
                end
            end
            if (s_tvalid && s_tready)
                expected_timing_q.push_back(predict_timing(s_tdata[3:0], s_tdata[35:4]));
        end
        fail_count    <= fails;
        pending_count <= expected_timing_q.size();
        result_count  <= n_results;
        ok_count      <= n_ok;
    end

endmodule

[dv/tb_timer_prescale_reload_calc_core.sv]
// Testbench top for the timer prescale/reload calculator.
// Drives APB set-up and request items with random idling; tprc_result_checker
// predicts and compares. Depends on tprc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_timer_prescale_reload_calc_core;
    import tprc_pkg::*;

    localparam logic [2:0] AddrCoreClock = {RegCoreClock, 2'b00};
    localparam logic [2:0] AddrApbDiv    = {RegApbDiv, 2'b00};
    localparam int         PhaseCount    = 10;
    localparam int         PhaseItems    = 125;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [3:0] timer_number, [35:4] frequency, [39:36] zero
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;         // [1:0] status, [17:2] prescale, [33:18] reload, rest zero

    int fail_count, pending_count, result_count, ok_count;
    int n_settings = 0;
    bit idle_on    = 1'b1;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    timer_prescale_reload_calc_core uut (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata
    );

    tprc_result_checker checker_i (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .fail_count, .pending_count, .result_count, .ok_count
    );

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // Hold the stream off, drain, then write and read back both registers
    task automatic set_timer_clock(input logic [31:0] core_hz, input logic [2:0] div_code);
        s_tvalid <= 1'b0;
        wait_idle();
        apb_access(1'b1, AddrCoreClock, core_hz);
        apb_access(1'b0, AddrCoreClock, '0);
        apb_access(1'b1, AddrApbDiv, {29'd0, div_code});
        apb_access(1'b0, AddrApbDiv, '0);
        n_settings++;
    endtask

    task automatic send_item(input logic [3:0] tnum, input logic [31:0] freq);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, freq, tnum};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [3:0] pick_timer();
        if ($urandom_range(0, 4) != 0) return 4'($urandom_range(1, 4));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [31:0] pick_frequency();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 3);
            2:       return $urandom >> $urandom_range(0, 31);
            3:       return $urandom_range(2, 200000);
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom >> $urandom_range(16, 28);
        endcase
    endfunction

    function automatic logic [31:0] pick_core_clock();
        if ($urandom_range(0, 1) == 0) return $urandom;
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // Stall the result side in bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(12_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [31:0] core_hz;
        logic [2:0]  div_code;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: read back, then the rejection paths and typical requests
        apb_access(1'b0, AddrCoreClock, '0);
        apb_access(1'b0, AddrApbDiv, '0);
        send_item(4'd0, 32'd1000);
        send_item(4'd15, 32'hFFFF_FFFF);
        send_item(4'd5, 32'd0);
        send_item(4'd1, 32'd0);
        send_item(4'd4, 32'd1);
        send_item(4'd2, 32'd2);
        send_item(4'd3, 32'hFFFF_FFFF);
        send_item(4'd1, 32'd1000);
        send_item(4'd4, 32'd244);
        send_item(4'd2, 32'd246);

        // Largest bus clock: prescaler overflow at the lowest frequencies
        set_timer_clock(32'hFFFF_FFFF, 3'd0);
        send_item(4'd1, 32'd2);
        send_item(4'd4, 32'd3);
        send_item(4'd2, 32'd4);
        send_item(4'd3, 32'hFFFF_FFFF);

        set_timer_clock(32'hFFFF_FFFF, 3'd7);
        send_item(4'd1, 32'd2);
        send_item(4'd1, 32'h7FFF_FFFF);

        set_timer_clock(32'd0, 3'd7);
        send_item(4'd2, 32'd2);
        send_item(4'd3, 32'hFFFF_FFFF);

        // Low divider codes divide by one
        set_timer_clock(32'd1, 3'd3);
        send_item(4'd4, 32'd2);
        send_item(4'd1, 32'd3);

        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph)
                0:       begin core_hz = 32'd72_000_000; div_code = 3'd4; end
                1:       begin core_hz = 32'hFFFF_FFFF;  div_code = 3'd0; end
                2:       begin core_hz = 32'hFFFF_FFFF;  div_code = 3'd7; end
                3:       begin core_hz = pick_core_clock(); div_code = 3'd1; end
                4:       begin core_hz = pick_core_clock(); div_code = 3'd2; end
                5:       begin core_hz = 32'hFFFF_0000 | $urandom_range(0, 65535);
                               div_code = 3'd3; end
                6:       begin core_hz = pick_core_clock(); div_code = 3'd5; end
                7:       begin core_hz = 32'd0;             div_code = 3'd6; end
                8:       begin core_hz = pick_core_clock(); div_code = 3'd6; end
                default: begin core_hz = pick_core_clock(); div_code = 3'($urandom_range(0, 7)); end
            endcase
            // No idling in the last phase
            idle_on = (ph != PhaseCount - 1) && ($urandom_range(0, 4) != 0);
            set_timer_clock(core_hz, div_code);
            for (int i = 0; i < PhaseItems; i++)
                send_item(pick_timer(), pick_frequency());
        end

        s_tvalid <= 1'b0;
        wait_idle();
        repeat (120) @(posedge aclk);
        $display("Covered %0d results (%0d in range, %0d rejected) over %0d clock settings,",
                 result_count, ok_count, result_count - ok_count, n_settings);
        $display("including divider codes 0 to 7 and core clocks of zero and all ones.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
